// ----- rtl/thrust_allocation_normalizer_unit_assert.svh -----
// assertion macros shared by the thrust allocation normalizer rtl
`ifndef THRUST_ALLOCATION_NORMALIZER_UNIT_ASSERT_SVH
`define THRUST_ALLOCATION_NORMALIZER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define TANORM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define TANORM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TANORM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TANORM_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- rtl/tanorm_pkg.sv -----
// types and constants of the thrust allocation normalizer
`timescale 1ns / 1ps
package tanorm_pkg;

    localparam int AXES      = 6;
    localparam int W_ACC     = 34;
    localparam int W_MAG     = 22;
    localparam int W_NUM     = 38;
    localparam int DIV_STEPS = 16;

    localparam logic [15:0] LIMIT_RESET = 16'd1600;

    localparam logic [1:0] CMD_WRENCH = 2'd0;
    localparam logic [1:0] CMD_COEF   = 2'd1;
    localparam logic [1:0] CMD_LIMIT  = 2'd2;

    typedef struct packed {
        logic             coef_we;
        logic             lim_we;
        logic [2:0]       load_thr;
        logic [2:0]       axis;
        logic [15:0]      load_data;
        logic [15:0]      wval;
        logic             mac_clr;
        logic             mac_en;
        logic             thr_en;
        logic             num_en;
        logic             div_start;
        logic             div_en;
        logic             scaled;
        logic [15:0]      lk;
        logic [W_MAG-1:0] tk;
    } t_lane_ctl;

    typedef struct packed {
        logic [W_MAG-1:0] mag;
        logic [15:0]      lim;
        logic [16:0]      effort;
    } t_lane_stat;

endpackage

// ----- rtl/tanorm_if.sv -----
// item channels of the thrust allocation normalizer
`timescale 1ns / 1ps
interface tanorm_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         cmd;
    logic signed [15:0] force_x;
    logic signed [15:0] force_y;
    logic signed [15:0] force_z;
    logic signed [15:0] torque_x;
    logic signed [15:0] torque_y;
    logic signed [15:0] torque_z;
    logic [2:0]         load_thruster;
    logic [2:0]         load_axis;
    logic signed [15:0] coef_value;
    logic [15:0]        limit_value;

    modport source (output valid, cmd, force_x, force_y, force_z, torque_x, torque_y,
                    torque_z, load_thruster, load_axis, coef_value, limit_value,
                    input ready);
    modport sink (input valid, cmd, force_x, force_y, force_z, torque_x, torque_y,
                  torque_z, load_thruster, load_axis, coef_value, limit_value,
                  output ready);
endinterface

interface tanorm_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         thruster_index;
    logic signed [16:0] effort;
    logic               scaled;
    logic               last;

    modport source (output valid, thruster_index, effort, scaled, last, input ready);
    modport sink (input valid, thruster_index, effort, scaled, last, output ready);
endinterface

// ----- rtl/tanorm_lane.sv -----
// one thruster lane: coefficient row, limit, dot product and divider
`timescale 1ns / 1ps
module tanorm_lane
    import tanorm_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_ctl  i_ctl,
    output t_lane_stat o_stat
);

    logic signed [15:0]      r_coef [AXES];
    logic [15:0]             r_lim;
    logic signed [W_ACC-1:0] r_acc;
    logic [W_MAG-1:0]        r_mag;
    logic                    r_neg;
    logic [W_NUM-1:0]        r_num;
    logic [W_MAG-1:0]        r_rem;
    logic [15:0]             r_quo;

    logic                    sel;
    logic signed [31:0]      prod;
    logic [W_ACC-1:0]        acc_u;
    logic [W_ACC-1:0]        acc_abs;
    logic [W_MAG:0]          shifted;
    logic [W_MAG:0]          divisor;
    logic [W_MAG:0]          diff;
    logic [15:0]             mag_out;
    logic [16:0]             e_abs;

    assign sel     = (int'(i_ctl.load_thr) == LANE);
    assign prod    = r_coef[i_ctl.axis] * $signed(i_ctl.wval);
    assign acc_u   = r_acc;
    assign acc_abs = acc_u[W_ACC-1] ? (~acc_u + W_ACC'(1)) : acc_u;
    assign shifted = {r_rem, r_quo[15]};
    assign divisor = {1'b0, i_ctl.tk};
    assign diff    = shifted - divisor;

    // coefficient row, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.coef_we && sel && (int'(i_ctl.axis) < AXES)) begin
            r_coef[i_ctl.axis] <= $signed(i_ctl.load_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim <= LIMIT_RESET;
        end else if (i_ctl.lim_we && sel) begin
            r_lim <= (i_ctl.load_data == 16'd0) ? 16'd1 : i_ctl.load_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mac_clr) begin
            r_acc <= '0;
        end else if (i_ctl.mac_en) begin
            r_acc <= r_acc + W_ACC'(prod);
        end
        if (i_ctl.thr_en) begin
            r_mag <= acc_abs[W_ACC-1:12];
            r_neg <= acc_u[W_ACC-1];
        end
        if (i_ctl.num_en) begin
            r_num <= W_NUM'(r_mag) * W_NUM'(i_ctl.lk);
        end
        // restoring division, high part of the numerator is below the divisor
        if (i_ctl.div_start) begin
            r_rem <= r_num[W_NUM-1:16];
            r_quo <= r_num[15:0];
        end else if (i_ctl.div_en) begin
            if (shifted >= divisor) begin
                r_rem <= diff[W_MAG-1:0];
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= shifted[W_MAG-1:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
    end

    assign mag_out = i_ctl.scaled ? r_quo : r_mag[15:0];
    assign e_abs   = {1'b0, mag_out};

    assign o_stat.mag    = r_mag;
    assign o_stat.lim    = r_lim;
    assign o_stat.effort = r_neg ? (~e_abs + 17'd1) : e_abs;

endmodule

// ----- rtl/tanorm_merge.sv -----
// merging stage: finds the thruster with the largest thrust to limit ratio
`timescale 1ns / 1ps
module tanorm_merge
    import tanorm_pkg::*;
#(
    parameter int LANES = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [$clog2(LANES+1)-1:0]   i_count,
    input  logic [W_MAG-1:0]             i_mag [LANES],
    input  logic [15:0]                  i_lim [LANES],
    output logic                         o_done,
    output logic [W_MAG-1:0]             o_tk,
    output logic [15:0]                  o_lk
);

    localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int CW = $clog2(LANES + 1);

    logic             r_busy;
    logic             r_ph;
    logic             r_done;
    logic [IW-1:0]    r_idx;
    logic [W_MAG-1:0] r_bmag;
    logic [15:0]      r_blim;
    logic [W_NUM-1:0] r_pa;
    logic [W_NUM-1:0] r_pb;
    logic             at_end;

    assign at_end = (CW'(r_idx) == (i_count - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph   <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_idx <= IW'(1);
                r_ph  <= 1'b0;
                if (i_count == CW'(1)) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_ph <= ~r_ph;
                if (r_ph) begin
                    if (at_end) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            end
        end
    end

    // cross products are registered, then compared in the next cycle; ties keep the earlier
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bmag <= i_mag[0];
            r_blim <= i_lim[0];
        end else if (r_busy) begin
            if (!r_ph) begin
                r_pa <= W_NUM'(i_mag[r_idx]) * W_NUM'(r_blim);
                r_pb <= W_NUM'(r_bmag) * W_NUM'(i_lim[r_idx]);
            end else if (r_pa > r_pb) begin
                r_bmag <= i_mag[r_idx];
                r_blim <= i_lim[r_idx];
            end
        end
    end

    assign o_done = r_done;
    assign o_tk   = r_bmag;
    assign o_lk   = r_blim;

endmodule

// ----- rtl/thrust_allocation_normalizer_unit.sv -----
// top level of the thrust allocation normalizer
`timescale 1ns / 1ps
// A wrench item (cmd 0) turns into one result item per thruster in use, in
// thruster order, the last one marked. Load items (cmd 1 coefficient, cmd 2
// limit) are taken while the block is idle and give no result; cmd 3 is
// dropped. Each thruster has a lane of its own holding its coefficient row and
// limit, so the six-term dot products run for all thrusters at once, one axis
// per cycle. The merging stage then walks the thrusters, forming the cross
// products and then comparing them for each, to find the largest thrust to
// limit ratio. If that thruster is over its limit, all lanes scale in
// parallel: a product, a load, and a 16-step restoring divider per lane. The
// block works on one wrench at a time; input ready is high only between
// wrenches, while the last result may still wait in the output register. The
// thruster count register resets to 8; 0 acts as 1 and values above
// MAX_THRUSTERS act as MAX_THRUSTERS.
`include "thrust_allocation_normalizer_unit_assert.svh"
module thrust_allocation_normalizer_unit
    import tanorm_pkg::*;
#(
    parameter int MAX_THRUSTERS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_wdata,
    tanorm_in_if.sink  i_item,
    tanorm_out_if.source o_result
);

    localparam int IW = (MAX_THRUSTERS > 1) ? $clog2(MAX_THRUSTERS) : 1;
    localparam int CW = $clog2(MAX_THRUSTERS + 1);

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MAC   = 4'd1;
    localparam logic [3:0] ST_THR   = 4'd2;
    localparam logic [3:0] ST_MGO   = 4'd3;
    localparam logic [3:0] ST_MERGE = 4'd4;
    localparam logic [3:0] ST_NUM   = 4'd5;
    localparam logic [3:0] ST_DST   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_EMIT  = 4'd8;

    logic [3:0]         r_state;
    logic [3:0]         r_cnt;
    logic [3:0]         r_cfg_count;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_ecnt;
    logic               r_scaled;
    logic [15:0]        r_w [AXES];

    // output register
    logic               r_ovalid;
    logic [2:0]         r_oidx;
    logic [16:0]        r_oeffort;
    logic               r_oscaled;
    logic               r_olast;

    logic               acc_item;
    logic               acc_wrench;
    logic               emit_load;
    logic               emit_last;
    logic [CW-1:0]      n_eff;
    t_lane_ctl          ctl;
    t_lane_stat         stat [MAX_THRUSTERS];
    logic [W_MAG-1:0]   lane_mag [MAX_THRUSTERS];
    logic [15:0]        lane_lim [MAX_THRUSTERS];
    logic               m_done;
    logic [W_MAG-1:0]   m_tk;
    logic [15:0]        m_lk;

    assign i_item.ready = (r_state == ST_IDLE);
    assign acc_item     = i_item.valid && i_item.ready;
    assign acc_wrench   = acc_item && (i_item.cmd == CMD_WRENCH);

    // clamp the count register into 1..MAX_THRUSTERS
    always_comb begin
        if (r_cfg_count == 4'd0) begin
            n_eff = CW'(1);
        end else if (int'(r_cfg_count) > MAX_THRUSTERS) begin
            n_eff = CW'(MAX_THRUSTERS);
        end else begin
            n_eff = CW'(r_cfg_count);
        end
    end

    always_comb begin
        ctl           = '0;
        ctl.coef_we   = acc_item && (i_item.cmd == CMD_COEF);
        ctl.lim_we    = acc_item && (i_item.cmd == CMD_LIMIT);
        ctl.load_thr  = i_item.load_thruster;
        ctl.axis      = (r_state == ST_IDLE) ? i_item.load_axis : r_cnt[2:0];
        ctl.load_data = (i_item.cmd == CMD_COEF) ? i_item.coef_value : i_item.limit_value;
        ctl.wval      = r_w[r_cnt[2:0]];
        ctl.mac_clr   = acc_wrench;
        ctl.mac_en    = (r_state == ST_MAC);
        ctl.thr_en    = (r_state == ST_THR);
        ctl.num_en    = (r_state == ST_NUM);
        ctl.div_start = (r_state == ST_DST);
        ctl.div_en    = (r_state == ST_DIV);
        ctl.scaled    = r_scaled;
        ctl.lk        = m_lk;
        ctl.tk        = m_tk;
    end

    // one lane per thruster
    for (genvar g = 0; g < MAX_THRUSTERS; g++) begin : g_lane
        tanorm_lane #(
            .LANE (g)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .o_stat  (stat[g])
        );
        assign lane_mag[g] = stat[g].mag;
        assign lane_lim[g] = stat[g].lim;
    end

    tanorm_merge #(
        .LANES (MAX_THRUSTERS)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_MGO),
        .i_count (r_n),
        .i_mag   (lane_mag),
        .i_lim   (lane_lim),
        .o_done  (m_done),
        .o_tk    (m_tk),
        .o_lk    (m_lk)
    );

    // a new result enters the output register when it is empty or drains
    assign emit_load = (r_state == ST_EMIT) && (!r_ovalid || o_result.ready);
    assign emit_last = (r_ecnt == (r_n - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= 4'd8;
        end else if (i_cfg_we) begin
            r_cfg_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_wrench) begin
            r_w[0] <= i_item.force_x;
            r_w[1] <= i_item.force_y;
            r_w[2] <= i_item.force_z;
            r_w[3] <= i_item.torque_x;
            r_w[4] <= i_item.torque_y;
            r_w[5] <= i_item.torque_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_n      <= CW'(1);
            r_ecnt   <= '0;
            r_scaled <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (acc_wrench) begin
                        r_n     <= n_eff;
                        r_state <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (r_cnt == 4'(AXES - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_THR;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_THR: begin
                    r_state <= ST_MGO;
                end
                ST_MGO: begin
                    r_state <= ST_MERGE;
                end
                ST_MERGE: begin
                    if (m_done) begin
                        r_ecnt   <= '0;
                        r_scaled <= (m_tk > W_MAG'(m_lk));
                        r_state  <= (m_tk > W_MAG'(m_lk)) ? ST_NUM : ST_EMIT;
                    end
                end
                ST_NUM: begin
                    r_state <= ST_DST;
                end
                ST_DST: begin
                    r_cnt   <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_cnt == 4'(DIV_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= ST_EMIT;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        r_ecnt <= r_ecnt + CW'(1);
                        if (emit_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_load) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_load) begin
            r_oidx    <= 3'(r_ecnt);
            r_oeffort <= stat[r_ecnt[IW-1:0]].effort;
            r_oscaled <= r_scaled;
            r_olast   <= emit_last;
        end
    end

    assign o_result.valid          = r_ovalid;
    assign o_result.thruster_index = r_oidx;
    assign o_result.effort         = r_oeffort;
    assign o_result.scaled         = r_oscaled;
    assign o_result.last           = r_olast;

    // wrench acceptance starts the dot products
    `TANORM_ASSERT_NXT(a_wrench_starts_mac, i_clk, i_rst_n, acc_wrench, r_state == ST_MAC)
    // the divider only runs when the thrusts must be scaled
    `TANORM_ASSERT_IMP(a_div_only_scaled, i_clk, i_rst_n, r_state == ST_DIV, r_scaled)
    // the merge stage reports only while it is awaited
    `TANORM_ASSERT_IMP(a_merge_done_in_merge, i_clk, i_rst_n, m_done, r_state == ST_MERGE)
    // the result counter never passes the thrusters in use
    `TANORM_ASSERT_IMP(a_emit_in_range, i_clk, i_rst_n, r_state == ST_EMIT, r_ecnt < r_n)

endmodule
